// File: src/hbc_pkg.sv
// Shared types, constants and helpers for the histogram pixel classifier.
package hbc_pkg;

    // Bin index: hue[7:6], saturation[7:4], brightness[7:4]
    localparam int BIN_IDX_BITS = 10;
    localparam int BIN_DEPTH    = 1 << BIN_IDX_BITS;

    // Item kinds
    localparam logic [1:0] KIND_TRAIN    = 2'd0;
    localparam logic [1:0] KIND_SEGMENT  = 2'd1;
    localparam logic [1:0] KIND_EVALUATE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MASK_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_OVERLAY_BLUE   = 2'd1;
    localparam logic [1:0] CFG_OVERLAY_GREEN  = 2'd2;
    localparam logic [1:0] CFG_OVERLAY_RED    = 2'd3;

    // Decoupling queue between front and back
    localparam int Q_PTR_BITS = 1;
    localparam int Q_DEPTH    = 1 << Q_PTR_BITS;

    // Classified word handed from the front to the back
    typedef struct packed {
        logic [1:0] kind;
        logic       pred;
        logic       label;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } hbc_word_t;

    // Overlay color
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } hbc_overlay_t;

    function automatic logic [BIN_IDX_BITS-1:0] bin_of(
        input logic [7:0] hue,
        input logic [7:0] sat,
        input logic [7:0] val
    );
        return {hue[7:6], sat[7:4], val[7:4]};
    endfunction

endpackage

// File: src/hbc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module hbc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/hbc_front.sv
// Front end: clearing sweep, pixel intake, histogram lookup, compare and training update.
module hbc_front #(
    parameter int BIN_COUNT_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        kind,
    input  logic [7:0]        hue,
    input  logic [7:0]        saturation,
    input  logic [7:0]        brightness,
    input  logic [7:0]        pix_blue,
    input  logic [7:0]        pix_green,
    input  logic [7:0]        pix_red,
    input  logic [7:0]        mask_byte,
    input  logic [7:0]        mask_threshold,
    input  logic              q_full,
    output logic              q_push,
    output hbc_pkg::hbc_word_t q_word
);
    import hbc_pkg::*;

    localparam int EW = 2 * BIN_COUNT_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } hbc_state_t;

    hbc_state_t              state_reg, state_next;
    logic [BIN_IDX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                    fwd_reg, fwd_next;
    logic [EW-1:0]           fwd_data_reg;
    logic [BIN_IDX_BITS-1:0] bin_reg;
    logic [1:0]              kind_reg;
    logic                    label_reg;
    logic [7:0]              blue_reg, green_reg, red_reg;

    logic [EW-1:0]             rd_data, entry, wr_data;
    logic [BIN_IDX_BITS-1:0]   rd_addr, wr_addr;
    logic [BIN_COUNT_BITS-1:0] floor_cnt, nonfloor_cnt, floor_inc, nonfloor_inc;
    logic                      we, accept, done, pred, train;

    assign done   = (state_reg == ST_LOOKUP) && !q_full;
    assign full   = !((state_reg == ST_IDLE) || done);
    assign accept = push && !full;
    assign rd_addr = bin_of(hue, saturation, brightness);

    // Take the just-written entry when the next pixel hits the same bin
    assign entry        = fwd_reg ? fwd_data_reg : rd_data;
    assign floor_cnt    = entry[EW-1:BIN_COUNT_BITS];
    assign nonfloor_cnt = entry[BIN_COUNT_BITS-1:0];
    assign pred         = floor_cnt > nonfloor_cnt;
    assign train        = (kind_reg == KIND_TRAIN);

    assign floor_inc    = (&floor_cnt) ? floor_cnt
                                       : floor_cnt + BIN_COUNT_BITS'(1);
    assign nonfloor_inc = (&nonfloor_cnt) ? nonfloor_cnt
                                          : nonfloor_cnt + BIN_COUNT_BITS'(1);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_data = '0;
        end
        else if (label_reg)
        begin
            wr_data = {floor_inc, nonfloor_cnt};
        end
        else
        begin
            wr_data = {floor_cnt, nonfloor_inc};
        end
    end

    assign we      = (state_reg == ST_CLEAR) || (done && train);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : bin_reg;

    hbc_ram #(
        .WIDTH (EW),
        .DEPTH (BIN_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_push       = done;
    assign q_word.kind  = kind_reg;
    assign q_word.pred  = pred;
    assign q_word.label = label_reg;
    assign q_word.blue  = pred ? blue_reg : blue_reg;
    assign q_word.green = green_reg;
    assign q_word.red   = red_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        fwd_next     = fwd_reg;
        if (accept)
        begin
            fwd_next = done && train && (rd_addr == bin_reg);
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + BIN_IDX_BITS'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (done && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            fwd_reg     <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
            bin_reg      <= rd_addr;
            kind_reg     <= kind;
            label_reg    <= mask_byte > mask_threshold;
            blue_reg     <= pix_blue;
            green_reg    <= pix_green;
            red_reg      <= pix_red;
        end
    end

endmodule

// File: src/hbc_fifo.sv
// Short queue of classified words between the front and the back.
module hbc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  hbc_pkg::hbc_word_t wr_word,
    output logic               q_full,
    input  logic               rd_en,
    output hbc_pkg::hbc_word_t rd_word,
    output logic               q_empty
);
    import hbc_pkg::*;

    hbc_word_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_BITS:0]   cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + (Q_PTR_BITS+1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - (Q_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// File: src/hbc_back.sv
// Back end: overlay blend, evaluation counters and the result register.
module hbc_back #(
    parameter int TOTAL_COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  hbc_pkg::hbc_word_t   q_word,
    output logic                 q_pop,
    input  hbc_pkg::hbc_overlay_t overlay,
    input  logic                 pop,
    output logic                 empty,
    output logic                 is_floor,
    output logic [7:0]           out_blue,
    output logic [7:0]           out_green,
    output logic [7:0]           out_red,
    output logic [31:0]          correct_total,
    output logic [31:0]          incorrect_total
);
    import hbc_pkg::*;

    localparam int TW = TOTAL_COUNT_BITS;

    logic          valid_reg;
    logic [TW-1:0] correct_reg, incorrect_reg;
    logic          is_floor_reg;
    logic [7:0]    blue_reg, green_reg, red_reg;

    logic          load;
    logic [8:0]    sum_b, sum_g, sum_r;
    logic [TW+31:0] ext_c, ext_i;

    assign load  = !q_empty && (!valid_reg || pop);
    assign q_pop = load;
    assign empty = !valid_reg;

    assign sum_b = {1'b0, q_word.blue}  + {1'b0, overlay.blue};
    assign sum_g = {1'b0, q_word.green} + {1'b0, overlay.green};
    assign sum_r = {1'b0, q_word.red}   + {1'b0, overlay.red};

    // Counters move only when the next word loads, so they match the shown result
    assign ext_c = {32'b0, correct_reg};
    assign ext_i = {32'b0, incorrect_reg};
    assign correct_total   = (ext_c[TW+31:32] != '0) ? '1 : ext_c[31:0];
    assign incorrect_total = (ext_i[TW+31:32] != '0) ? '1 : ext_i[31:0];

    assign is_floor  = is_floor_reg;
    assign out_blue  = blue_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            correct_reg   <= '0;
            incorrect_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
            if (load && (q_word.kind == KIND_EVALUATE))
            begin
                if (q_word.pred == q_word.label)
                begin
                    if (!(&correct_reg))
                    begin
                        correct_reg <= correct_reg + TW'(1);
                    end
                end
                else if (!(&incorrect_reg))
                begin
                    incorrect_reg <= incorrect_reg + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_floor_reg <= q_word.pred;
            blue_reg     <= q_word.pred ? sum_b[8:1] : q_word.blue;
            green_reg    <= q_word.pred ? sum_g[8:1] : q_word.green;
            red_reg      <= q_word.pred ? sum_r[8:1] : q_word.red;
        end
    end

endmodule

// File: src/histogram_bayes_pixel_classifier.sv
// Top level of the histogram pixel classifier: config registers, front, queue, back.
//
//  channel   direction  handshake            word
//  pixel     in         push / full          kind, hue, saturation, brightness,
//                                            pix_blue, pix_green, pix_red, mask_byte
//  result    out        empty / pop          is_floor, out_blue, out_green, out_red,
//                                            correct_total, incorrect_total
//  config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// Throughput is one pixel word per clock while the queue has room: the front takes
// a word, reads the bin pair from the histogram RAM the cycle after, and writes
// the trained count back as the word goes to the queue, while taking the next
// word; a hit on the bin just written is forwarded. A word passes the front's lookup
// registers, the queue and the result register. After reset the front sweeps the
// 1024 histogram bins to zero, one bin a cycle, holding full high; config writes
// are taken throughout. The two-word queue lets the front keep going while a
// result waits for pop; when it fills, full rises and the front holds its lookup.
module histogram_bayes_pixel_classifier #(
    parameter int BIN_COUNT_BITS   = 24,
    parameter int TOTAL_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    input  logic [7:0]  pix_blue,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_red,
    input  logic [7:0]  mask_byte,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        is_floor,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic [31:0] correct_total,
    output logic [31:0] incorrect_total,
    // config port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import hbc_pkg::*;

    logic         [7:0] mask_threshold_reg;
    hbc_overlay_t       overlay_reg;

    hbc_word_t front_word, back_word;
    logic      q_push, q_pop, q_full, q_empty;

    // Config writes land directly; the user must write them only while the block is idle, which it does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_threshold_reg <= 8'd128;
            overlay_reg.blue   <= 8'd0;
            overlay_reg.green  <= 8'd0;
            overlay_reg.red    <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASK_THRESHOLD: mask_threshold_reg <= cfg_data;
                CFG_OVERLAY_BLUE:   overlay_reg.blue   <= cfg_data;
                CFG_OVERLAY_GREEN:  overlay_reg.green  <= cfg_data;
                CFG_OVERLAY_RED:    overlay_reg.red    <= cfg_data;
                default:            mask_threshold_reg <= mask_threshold_reg;
            endcase
        end
    end

    // Front: intake, histogram lookup, compare, training write-back
    hbc_front #(
        .BIN_COUNT_BITS (BIN_COUNT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .hue            (hue),
        .saturation     (saturation),
        .brightness     (brightness),
        .pix_blue       (pix_blue),
        .pix_green      (pix_green),
        .pix_red        (pix_red),
        .mask_byte      (mask_byte),
        .mask_threshold (mask_threshold_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_word         (front_word)
    );

    // Queue: decouple lookup from result delivery
    hbc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (front_word),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_word (back_word),
        .q_empty (q_empty)
    );

    // Back: blend, evaluation counters, result register
    hbc_back #(
        .TOTAL_COUNT_BITS (TOTAL_COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_word          (back_word),
        .q_pop           (q_pop),
        .overlay         (overlay_reg),
        .pop             (pop),
        .empty           (empty),
        .is_floor        (is_floor),
        .out_blue        (out_blue),
        .out_green       (out_green),
        .out_red         (out_red),
        .correct_total   (correct_total),
        .incorrect_total (incorrect_total)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the histogram pixel classifier: directed table, then random words.
`timescale 1ns / 100ps

module tb_top;
    import hbc_pkg::*;

    localparam int          RESET_CYCLES    = 11;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PHASES          = 6;
    localparam int          WORDS_PER_PHASE = 255;
    localparam int          POOL_SIZE       = 8;
    localparam int          HOLD_OFF_AFTER  = 600;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          TAIL_CYCLES     = 20;
    localparam logic [1:0]  KIND_UNUSED     = 2'd3;
    localparam logic [23:0] BIN_FULL        = '1;
    localparam logic [31:0] TOTAL_FULL      = '1;

    // One pixel word as offered on the input side
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] mask;
    } pixel_t;

    // One result word as popped from the output side
    typedef struct packed {
        logic        is_floor;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] correct;
        logic [31:0] incorrect;
    } verdict_t;

    // A hand-written expectation travels with its pixel; when typed is low,
    // the predictor supplies the expectation instead.
    typedef struct packed {
        logic     typed;
        verdict_t res;
    } note_t;

    typedef struct packed {
        pixel_t px;
        note_t  note;
    } row_t;

    localparam int DIRECTED_COUNT = 20;

    // Directed table. The reset overlay is (0, 0, 255) and the threshold 128,
    // so mask 0x80 is a non-floor label and 0x81 a floor label. Bin zero is
    // trained up to floor 2 / non-floor 1, the top bin to floor 1.
    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty bins at both ends of the index, and the unused kind
        '{'{KIND_SEGMENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 32'd0, 32'd0}}},
        '{'{KIND_SEGMENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          '{1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 32'd0, 32'd0}}},
        '{'{KIND_UNUSED, 8'h80, 8'h80, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h80},
          '{1'b1, '{1'b0, 8'hAA, 8'h55, 8'hFF, 32'd0, 32'd0}}},
        // train bin zero: floor, then non-floor (prediction is taken before update)
        '{'{KIND_TRAIN, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h81},
          '{1'b1, '{1'b0, 8'h01, 8'h02, 8'h03, 32'd0, 32'd0}}},
        '{'{KIND_TRAIN, 8'h3F, 8'h0F, 8'h0F, 8'h10, 8'h20, 8'h30, 8'h80},
          '{1'b1, '{1'b1, 8'h08, 8'h10, 8'h97, 32'd0, 32'd0}}},
        // equal counts call non-floor
        '{'{KIND_SEGMENT, 8'h00, 8'h00, 8'h00, 8'h55, 8'hAA, 8'h00, 8'h00},
          '{1'b1, '{1'b0, 8'h55, 8'hAA, 8'h00, 32'd0, 32'd0}}},
        '{'{KIND_TRAIN, 8'h3F, 8'h0F, 8'h0F, 8'h00, 8'h00, 8'h00, 8'hFF},
          '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 32'd0, 32'd0}}},
        '{'{KIND_SEGMENT, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00},
          '{1'b1, '{1'b1, 8'h7F, 8'h7F, 8'hFF, 32'd0, 32'd0}}},
        // evaluate: agree and disagree on a floor bin and on an empty bin
        '{'{KIND_EVALUATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC8},
          '{1'b1, '{1'b1, 8'h00, 8'h00, 8'h7F, 32'd1, 32'd0}}},
        '{'{KIND_EVALUATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          '{1'b1, '{1'b1, 8'h00, 8'h00, 8'h7F, 32'd1, 32'd1}}},
        '{'{KIND_EVALUATE, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h00},
          '{1'b1, '{1'b0, 8'h12, 8'h34, 8'h56, 32'd2, 32'd1}}},
        '{'{KIND_EVALUATE, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'hFF},
          '{1'b1, '{1'b0, 8'h12, 8'h34, 8'h56, 32'd2, 32'd2}}},
        // train the top bin through its lowest pixel, then read it at its highest
        '{'{KIND_TRAIN, 8'hC0, 8'hF0, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h81},
          '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 32'd2, 32'd2}}},
        '{'{KIND_SEGMENT, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h00},
          '{1'b1, '{1'b1, 8'h00, 8'h01, 8'h81, 32'd2, 32'd2}}},
        // the rest is left to the predictor
        '{'{KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFF}, '{1'b0, '0}},
        '{'{KIND_TRAIN, 8'h40, 8'h10, 8'h10, 8'h5A, 8'hA5, 8'h3C, 8'h7F}, '{1'b0, '0}},
        '{'{KIND_EVALUATE, 8'h7F, 8'h1F, 8'h1F, 8'hC3, 8'h3C, 8'h99, 8'h80}, '{1'b0, '0}},
        '{'{KIND_SEGMENT, 8'hBF, 8'hEF, 8'hDF, 8'h5A, 8'hA5, 8'h3C, 8'h00}, '{1'b0, '0}},
        '{'{KIND_UNUSED, 8'h80, 8'h20, 8'h30, 8'h11, 8'h22, 8'h33, 8'h81}, '{1'b0, '0}},
        '{'{KIND_SEGMENT, 8'h80, 8'h20, 8'h30, 8'h44, 8'h55, 8'h66, 8'h00}, '{1'b0, '0}}
    };

    // ---------------------------------------------------------------- signals
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [1:0]  kind       = KIND_TRAIN;
    logic [7:0]  hue        = '0;
    logic [7:0]  saturation = '0;
    logic [7:0]  brightness = '0;
    logic [7:0]  pix_blue   = '0;
    logic [7:0]  pix_green  = '0;
    logic [7:0]  pix_red    = '0;
    logic [7:0]  mask_byte  = '0;
    logic        empty;
    logic        pop        = 1'b0;
    logic        is_floor;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [31:0] correct_total;
    logic [31:0] incorrect_total;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = CFG_MASK_THRESHOLD;
    logic [7:0]  cfg_data   = '0;

    histogram_bayes_pixel_classifier DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .hue             (hue),
        .saturation      (saturation),
        .brightness      (brightness),
        .pix_blue        (pix_blue),
        .pix_green       (pix_green),
        .pix_red         (pix_red),
        .mask_byte       (mask_byte),
        .empty           (empty),
        .pop             (pop),
        .is_floor        (is_floor),
        .out_blue        (out_blue),
        .out_green       (out_green),
        .out_red         (out_red),
        .correct_total   (correct_total),
        .incorrect_total (incorrect_total),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------ classifier model
    // Own copy of both histograms, the agreement totals and the registers.
    logic [23:0] floor_count [BIN_DEPTH];
    logic [23:0] other_count [BIN_DEPTH];
    logic [31:0] agree_total;
    logic [31:0] disagree_total;
    logic [7:0]  thr_reg;
    logic [7:0]  ovl_blue;
    logic [7:0]  ovl_green;
    logic [7:0]  ovl_red;

    // Expectations in acceptance order, plus the notes of words on offer
    verdict_t    expect_q [$];
    note_t       note_q [$];

    int          mismatches     = 0;
    int          results_seen   = 0;
    int          floor_calls    = 0;
    int          stall_cycles   = 0;
    int          kind_words [4] = '{0, 0, 0, 0};
    int          cycle_count    = 0;

    // Half-and-half blend of a pixel byte with an overlay byte
    function automatic logic [7:0] mix(input logic [7:0] pix, input logic [7:0] ovl);
        logic [8:0] sum;
        sum = {1'b0, pix} + {1'b0, ovl};
        return sum[8:1];
    endfunction

    // Classify one pixel against the counts as they stand, then apply the
    // training or evaluation update. Counts and totals hold at full scale.
    function automatic verdict_t classify_pixel(input pixel_t px);
        logic [9:0] bin;
        logic       label;
        logic       call;
        verdict_t   res;
        bin   = {px.hue[7:6], px.sat[7:4], px.val[7:4]};
        label = px.mask > thr_reg;
        call  = floor_count[bin] > other_count[bin];
        case (px.kind)
            KIND_TRAIN:
            begin
                if (label && floor_count[bin] != BIN_FULL)
                    floor_count[bin] = floor_count[bin] + 24'd1;
                else if (!label && other_count[bin] != BIN_FULL)
                    other_count[bin] = other_count[bin] + 24'd1;
            end
            KIND_EVALUATE:
            begin
                if (call == label && agree_total != TOTAL_FULL)
                    agree_total = agree_total + 32'd1;
                else if (call != label && disagree_total != TOTAL_FULL)
                    disagree_total = disagree_total + 32'd1;
            end
            default: ; // segment and the unused kind leave state alone
        endcase
        res.is_floor  = call;
        res.blue      = call ? mix(px.blue, ovl_blue) : px.blue;
        res.green     = call ? mix(px.green, ovl_green) : px.green;
        res.red       = call ? mix(px.red, ovl_red) : px.red;
        res.correct   = agree_total;
        res.incorrect = disagree_total;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // -------------------------------------------------------------- monitor
    // Sample every handshake at the rising edge. Results are checked before
    // the new word is predicted: a word cannot come out on the edge that
    // takes it in.
    always @(posedge clk)
    begin
        verdict_t predicted;
        verdict_t want;
        note_t    note;
        if (!rst_n)
        begin
            for (int b = 0; b < BIN_DEPTH; b++)
            begin
                floor_count[b] = '0;
                other_count[b] = '0;
            end
            agree_total    = '0;
            disagree_total = '0;
            thr_reg        = 8'd128;
            ovl_blue       = 8'd0;
            ovl_green      = 8'd0;
            ovl_red        = 8'd255;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASK_THRESHOLD: thr_reg   = cfg_data;
                    CFG_OVERLAY_BLUE:   ovl_blue  = cfg_data;
                    CFG_OVERLAY_GREEN:  ovl_green = cfg_data;
                    CFG_OVERLAY_RED:    ovl_red   = cfg_data;
                    default: ;
                endcase
            end

            if (pop && empty === 1'b0)
            begin
                results_seen++;
                if (expect_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected (is_floor %0b)",
                             $time, is_floor);
                    mismatches++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    check_field("is_floor", 32'(want.is_floor), 32'(is_floor));
                    check_field("out_blue", 32'(want.blue), 32'(out_blue));
                    check_field("out_green", 32'(want.green), 32'(out_green));
                    check_field("out_red", 32'(want.red), 32'(out_red));
                    check_field("correct_total", want.correct, correct_total);
                    check_field("incorrect_total", want.incorrect, incorrect_total);
                end
            end

            if (push && full === 1'b0)
            begin
                predicted = classify_pixel('{kind, hue, saturation, brightness,
                                             pix_blue, pix_green, pix_red, mask_byte});
                note = (note_q.size() != 0) ? note_q.pop_front() : '0;
                expect_q.insert(expect_q.size(), note.typed ? note.res : predicted);
                kind_words[kind]++;
                if (predicted.is_floor)
                    floor_calls++;
            end
            else if (push && full === 1'b1)
            begin
                stall_cycles++;
            end
        end
    end

    // Hard stop for a hung handshake; covers the post-reset clearing sweep
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------- idling
    // Mostly back to back or short gaps, now and then a long one; in steady
    // stretches no gap at all.
    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    bit send_steady = 1'b0;

    // Offer one word and hold it until it is taken. Entered and left on a
    // rising edge; push gets one assignment per edge.
    task automatic send_word(input pixel_t px, input note_t note);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = pick_gap(send_steady);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_q.insert(note_q.size(), note);
        push       <= 1'b1;
        kind       <= px.kind;
        hue        <= px.hue;
        saturation <= px.sat;
        brightness <= px.val;
        pix_blue   <= px.blue;
        pix_green  <= px.green;
        pix_red    <= px.red;
        mask_byte  <= px.mask;
        @(posedge clk);
        while (!(push && full === 1'b0))
            @(posedge clk);
    endtask

    // Drop push and wait until every taken word has come back. The first edge
    // lets the monitor log a word taken on the current edge.
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------- receiver
    // Pop with random gaps; once, far into the run, hold off for a long
    // stretch so the output queue backs up and full rises on the input.
    initial
    begin : result_side
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_OFF_AFTER)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                gap = pick_gap(steady);
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            @(posedge clk);
            while (!(pop && empty === 1'b0))
                @(posedge clk);
            taken++;
        end
    end

    // -------------------------------------------------------------- stimulus
    initial
    begin : pixel_side
        logic [9:0]  pool_bins [POOL_SIZE];
        bit          pool_floor [POOL_SIZE];
        logic [9:0]  bin;
        logic [31:0] bits;
        logic [7:0]  s_thr;
        logic [7:0]  s_blue;
        logic [7:0]  s_green;
        logic [7:0]  s_red;
        pixel_t      px;
        int          slot;
        int          roll;
        int          thr_i;
        int          settings_used;

        settings_used = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table runs under reset register values; the first word
        // waits out the clearing sweep on full.
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_word(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].note);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Registers change only with nothing in flight
            wait_for_drain();
            case (phase)
                0:       begin s_thr = 8'd128; s_blue = 8'h00; s_green = 8'h00; s_red = 8'hFF; end
                1:       begin s_thr = 8'h00;  s_blue = 8'hFF; s_green = 8'hFF; s_red = 8'h00; end
                2:       begin s_thr = 8'hFF;  s_blue = 8'h00; s_green = 8'hFF; s_red = 8'h80; end
                3:       begin s_thr = 8'h01;  s_blue = 8'h55; s_green = 8'hAA; s_red = 8'hFE; end
                default:
                begin
                    s_thr   = 8'($urandom_range(0, 255));
                    s_blue  = 8'($urandom_range(0, 255));
                    s_green = 8'($urandom_range(0, 255));
                    s_red   = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_MASK_THRESHOLD, s_thr);
            write_reg(CFG_OVERLAY_BLUE, s_blue);
            write_reg(CFG_OVERLAY_GREEN, s_green);
            write_reg(CFG_OVERLAY_RED, s_red);
            cfg_we <= 1'b0;
            settings_used++;
            thr_i = int'(s_thr);

            // A handful of hot bins per phase, each leaning to one label, so
            // counts build up and floor calls actually happen.
            for (int s = 0; s < POOL_SIZE; s++)
            begin
                pool_bins[s]  = 10'($urandom_range(0, BIN_DEPTH - 1));
                pool_floor[s] = 1'($urandom_range(0, 1));
            end

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Pause the sender mid-phase until the block has drained
                if (phase == 2 && n == WORDS_PER_PHASE / 2)
                    wait_for_drain();

                slot = $urandom_range(0, POOL_SIZE - 1);
                bin  = ($urandom_range(0, 99) < 15) ? 10'($urandom_range(0, BIN_DEPTH - 1))
                                                    : pool_bins[slot];
                bits = $urandom();
                px.hue = {bin[9:8], bits[5:0]};
                px.sat = {bin[7:4], bits[11:8]};
                px.val = {bin[3:0], bits[15:12]};

                roll = $urandom_range(0, 99);
                if (roll < 45)
                    px.kind = KIND_TRAIN;
                else if (roll < 70)
                    px.kind = KIND_SEGMENT;
                else if (roll < 95)
                    px.kind = KIND_EVALUATE;
                else
                    px.kind = KIND_UNUSED;

                // Label follows the bin's lean most of the time
                if ($urandom_range(0, 9) < 7 && !(pool_floor[slot] && thr_i == 255))
                    px.mask = pool_floor[slot] ? 8'($urandom_range(255, thr_i + 1))
                                               : 8'($urandom_range(thr_i, 0));
                else
                    px.mask = pick_byte();

                px.blue  = pick_byte();
                px.green = pick_byte();
                px.red   = pick_byte();
                send_word(px, '0);
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d pixel words (train %0d, segment %0d, evaluate %0d, unused %0d)",
                 kind_words[0] + kind_words[1] + kind_words[2] + kind_words[3],
                 kind_words[KIND_TRAIN], kind_words[KIND_SEGMENT],
                 kind_words[KIND_EVALUATE], kind_words[KIND_UNUSED]);
        $display("over %0d register settings: %0d results, %0d floor calls, %0d full stalls",
                 settings_used, results_seen, floor_calls, stall_cycles);
        if (mismatches == 0 && expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/hbc_pkg.sv
src/hbc_ram.sv
src/hbc_front.sv
src/hbc_fifo.sv
src/hbc_back.sv
src/histogram_bayes_pixel_classifier.sv
tb/sv/tb_top.sv
